// ===== design/rtt_pkg.sv =====
package rtt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int KIND_COUNT    = 3;
  localparam int IDENT_BITS    = 32;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int OCC_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int KIND_W = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
  localparam int CNT_W  = 32;

  // Port field widths
  localparam int MODE_W   = 2;
  localparam int TYPE_W   = 2;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int OCCO_W   = 9;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = MODE_W + TYPE_W;
  localparam int M_TDATA_W = 152;
  localparam int M_TUSER_W = STATUS_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    MODE_REG   = 2'd0,
    MODE_UNREG = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_TYPE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TBL_IDLE,
    TBL_SCAN,
    TBL_HOLD
  } tbl_state_e;

  typedef enum logic {
    CTL_IDLE,
    CTL_RUN
  } ctl_state_e;

  typedef struct packed {
    logic [IDENT_BITS-1:0] ident;
    logic [KIND_W-1:0]     kind;
  } entry_t;

  // Control toward the table engine
  typedef struct packed {
    logic                  start;
    logic                  commit;
    logic                  unreg;
    logic [IDENT_BITS-1:0] ident;
    logic [KIND_W-1:0]     kind;
  } rtt_req_t;

  // Scan outcome back from the table engine
  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] slot;
    logic [OCC_W-1:0] occ_next;
  } rtt_resp_t;

endpackage

// ===== design/rtt_table.sv =====
module rtt_table
  import rtt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rtt_req_t  req_i,
  output rtt_resp_t resp_o
);

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [OCC_W-1:0]         occ_q, occ_d;

  tbl_state_e state_q, state_d;

  logic [IDX_W-1:0]      addr_q, cmp_idx_q, slot_q;
  logic                  issue_q, cmp_q, vld_s_q, found_q, unreg_q;
  logic [IDENT_BITS-1:0] ident_q;
  logic [KIND_W-1:0]     kind_q;

  logic hit, commit_now;

  // Compare stage: free slot for register, id/kind match for release
  always_comb begin
    if (unreg_q) begin
      hit = cmp_q && vld_s_q && (rd_q.ident == ident_q) && (rd_q.kind == kind_q);
    end else begin
      hit = cmp_q && !vld_s_q;
    end
  end

  assign commit_now = (state_q == TBL_HOLD) && req_i.commit;

  // Occupancy after the pending update
  always_comb begin
    occ_d = occ_q;
    if ((state_q == TBL_HOLD) && found_q) begin
      if (unreg_q) begin
        if (occ_q != '0) begin
          occ_d = occ_q - OCC_W'(1);
        end
      end else begin
        occ_d = occ_q + OCC_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TBL_IDLE: begin
        if (req_i.start) begin
          state_d = TBL_SCAN;
        end
      end
      TBL_SCAN: begin
        if (hit || (cmp_q && (cmp_idx_q == LAST_IDX))) begin
          state_d = TBL_HOLD;
        end
      end
      TBL_HOLD: begin
        if (req_i.commit) begin
          state_d = TBL_IDLE;
        end
      end
      default: state_d = TBL_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TBL_IDLE;
      valid_q <= '0;
      occ_q   <= '0;
      issue_q <= 1'b0;
      cmp_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == TBL_IDLE && req_i.start) begin
        issue_q <= 1'b1;
        cmp_q   <= 1'b0;
        found_q <= 1'b0;
      end else if (state_q == TBL_SCAN) begin
        cmp_q <= issue_q;
        if (issue_q && (addr_q == LAST_IDX)) begin
          issue_q <= 1'b0;
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (commit_now) begin
        occ_q <= occ_d;
        if (found_q) begin
          valid_q[slot_q] <= !unreg_q;
        end
      end
    end
  end

  // Scan address, request latch and compare-stage payload
  always_ff @(posedge clk_i) begin
    if (state_q == TBL_IDLE && req_i.start) begin
      addr_q  <= '0;
      unreg_q <= req_i.unreg;
      ident_q <= req_i.ident;
      kind_q  <= req_i.kind;
    end else if (state_q == TBL_SCAN) begin
      if (issue_q) begin
        addr_q    <= addr_q + IDX_W'(1);
        cmp_idx_q <= addr_q;
        vld_s_q   <= valid_q[addr_q];
      end
      if (hit) begin
        slot_q <= cmp_idx_q;
      end
    end
  end

  // Entry memory: one read, one write port
  always_ff @(posedge clk_i) begin
    if (commit_now && found_q && !unreg_q) begin
      mem_q[slot_q] <= '{ident: ident_q, kind: kind_q};
    end
    rd_q <= mem_q[addr_q];
  end

  assign resp_o.done     = (state_q == TBL_HOLD);
  assign resp_o.found    = (state_q == TBL_HOLD) && found_q;
  assign resp_o.slot     = slot_q;
  assign resp_o.occ_next = occ_d;

`ifndef ASSERT_OFF
  // Occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OCC_W'($countones(valid_q)))
    else $error("occupied count differs from valid bits");

  // A committed registration leaves its slot valid
  a_reg_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_now && found_q && !unreg_q) |=> valid_q[$past(slot_q)])
    else $error("registered slot not marked valid");

  // A release hit must point at a slot that is really valid
  a_unreg_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TBL_SCAN && hit && unreg_q) |-> valid_q[cmp_idx_q])
    else $error("release matched an empty slot");

  // Occupancy never passes the table size
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= TABLE_ENTRIES)
    else $error("occupied count above table size");
`endif

endmodule

// ===== design/resource_tracking_table_unit.sv =====
// Handle tracking table with per-type usage counters.
// Input stream (s_axis_*): one beat per request. tuser carries mode (register,
// release, clear counters, query) and resource type; tdata carries the id.
// Output stream (m_axis_*): exactly one beat per request. tuser is the status,
// tdata holds slot, occupied count and the four counters of the request's type
// after the update.
// Requests are handled one at a time. Register and release walk the entry
// memory from slot 0, one slot per cycle through a single registered read
// port, and stop at the first free or matching slot, or after the last slot
// when nothing is found. Clear, query and invalid-type requests do not walk
// the table.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls, a second finished result waits in
// the engine until the register frees up, and s_axis_tready stays low.
// Reset empties the table (valid bits) and zeroes all counters at once; no
// clearing pass is needed.
module resource_tracking_table_unit
  import rtt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] entry_id
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [1:0] mode, [3:2] resource_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] slot_index, [16:8] occupied_count, [48:17] created_total,
  // [80:49] deleted_total, [112:81] live_now, [144:113] live_peak, rest zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [M_TUSER_W-1:0] m_axis_tuser   // [1:0] status
);

  ctl_state_e state_q, state_d;

  logic [CNT_W-1:0] cre_q [KIND_COUNT];
  logic [CNT_W-1:0] del_q [KIND_COUNT];
  logic [CNT_W-1:0] live_q[KIND_COUNT];
  logic [CNT_W-1:0] peak_q[KIND_COUNT];

  mode_e             mode_in, mode_q;
  logic [KIND_W-1:0] kind_q;
  logic              kind_ok_in, kind_ok_q, scan_in, scan_q;

  rtt_req_t  req;
  rtt_resp_t resp;

  logic accept, ready_now, load;
  logic reg_ok, unreg_ok;

  logic [CNT_W-1:0] cre_nx, del_nx, live_nx, peak_nx;
  status_e          status_nx;

  logic             m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic [M_TUSER_W-1:0] m_user_q;

  // Input decode
  assign mode_in    = mode_e'(s_axis_tuser[MODE_W-1:0]);
  assign kind_ok_in = 32'(s_axis_tuser[S_TUSER_W-1:MODE_W]) < KIND_COUNT;
  assign scan_in    = kind_ok_in && (mode_in == MODE_REG || mode_in == MODE_UNREG);

  assign s_axis_tready = (state_q == CTL_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Table engine
  always_comb begin
    req.start  = accept && scan_in;
    req.commit = load;
    req.unreg  = (mode_in == MODE_UNREG);
    req.ident  = IDENT_BITS'(s_axis_tdata);
    req.kind   = KIND_W'(s_axis_tuser[S_TUSER_W-1:MODE_W]);
  end

  rtt_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .resp_o (resp)
  );

  // Result ready and output register free
  assign ready_now = !scan_q || resp.done;
  assign load      = (state_q == CTL_RUN) && ready_now && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: if (accept) state_d = CTL_RUN;
      CTL_RUN:  if (load) state_d = CTL_IDLE;
      default:  state_d = CTL_IDLE;
    endcase
  end

  // Counter update for the request's type
  assign reg_ok   = scan_q && resp.found && (mode_q == MODE_REG);
  assign unreg_ok = scan_q && resp.found && (mode_q == MODE_UNREG);

  always_comb begin
    cre_nx  = cre_q[kind_q];
    del_nx  = del_q[kind_q];
    live_nx = live_q[kind_q];
    peak_nx = peak_q[kind_q];
    if (reg_ok) begin
      cre_nx  = cre_nx + CNT_W'(1);
      live_nx = live_nx + CNT_W'(1);
    end
    if (unreg_ok) begin
      del_nx = del_nx + CNT_W'(1);
      if (live_nx != '0) begin
        live_nx = live_nx - CNT_W'(1);
      end
    end
    if (live_nx > peak_nx) begin
      peak_nx = live_nx;
    end
    if (!kind_ok_q || mode_q == MODE_CLEAR) begin
      cre_nx  = '0;
      del_nx  = '0;
      live_nx = '0;
      peak_nx = '0;
    end
  end

  always_comb begin
    if (!kind_ok_q) begin
      status_nx = ST_BAD_TYPE;
    end else if (scan_q && !resp.found) begin
      status_nx = (mode_q == MODE_REG) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      status_nx = ST_OK;
    end
  end

  // Control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CTL_IDLE;
      m_valid_q <= 1'b0;
      for (int k = 0; k < KIND_COUNT; k++) begin
        cre_q[k]  <= '0;
        del_q[k]  <= '0;
        live_q[k] <= '0;
        peak_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (load && kind_ok_q) begin
        if (mode_q == MODE_CLEAR) begin
          for (int k = 0; k < KIND_COUNT; k++) begin
            cre_q[k]  <= '0;
            del_q[k]  <= '0;
            live_q[k] <= '0;
            peak_q[k] <= '0;
          end
        end else begin
          cre_q[kind_q]  <= cre_nx;
          del_q[kind_q]  <= del_nx;
          live_q[kind_q] <= live_nx;
          peak_q[kind_q] <= peak_nx;
        end
      end
    end
  end

  // Request latch and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_in;
      kind_q    <= KIND_W'(s_axis_tuser[S_TUSER_W-1:MODE_W]);
      kind_ok_q <= kind_ok_in;
      scan_q    <= scan_in;
    end
    if (load) begin
      m_user_q <= M_TUSER_W'(status_nx);
      m_data_q <= {7'd0, peak_nx, live_nx, del_nx, cre_nx,
                   OCCO_W'(resp.occ_next),
                   (status_nx == ST_OK && scan_q) ? SLOT_W'(resp.slot) : SLOT_W'(0)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  // Table engine only starts from an idle controller
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> (state_q == CTL_IDLE))
    else $error("table scan started while busy");

  // A result is never loaded while a scan is still running
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && scan_q) |-> resp.done)
    else $error("result loaded before scan finished");

  // Live count of any loaded result never passes the peak
  a_live_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (live_nx <= peak_nx))
    else $error("live count above peak");
`endif

endmodule
